FILE: hdl/ctss_pkg.sv
package ctss_pkg;

    // Table geometry
    localparam int ENTRIES   = 8;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int OUT_IDX_W = 3;

    // Operation codes
    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_LIST    = 3'd1,
        OP_SORT    = 3'd2,
        OP_SSEARCH = 3'd3,
        OP_BSEARCH = 3'd4
    } op_e;

    // Status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_FEW   = 3'd3;
    localparam logic [2:0] ST_MISS  = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic [63:0]        key_word_high;
        logic [63:0]        key_word_mid;
        logic [23:0]        key_word_low;
        logic signed [31:0] phone_in;
    } req_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [OUT_IDX_W-1:0] entry_index;
        logic [63:0]          name_high_out;
        logic [63:0]          name_mid_out;
        logic [23:0]          name_low_out;
        logic signed [31:0]   phone_out;
        logic                 last;
    } rsp_t;

    // 152-bit key, compared as one unsigned big-endian number
    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] mid;
        logic [23:0] lo;
    } key_t;

    typedef struct packed {
        key_t        key;
        logic [31:0] phone;
    } entry_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

    // Table position to the 3-bit reported index (wraps for wide tables)
    function automatic logic [OUT_IDX_W-1:0] out_idx(input logic [CNT_W-1:0] v);
        logic [CNT_W+OUT_IDX_W-1:0] ext;
        ext = {{OUT_IDX_W{1'b0}}, v};
        return ext[OUT_IDX_W-1:0];
    endfunction

    function automatic rsp_t make_status(input logic [2:0] st);
        rsp_t r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic rsp_t make_entry(input entry_t e, input logic [CNT_W-1:0] pos,
                                        input logic lst);
        rsp_t r;
        r.status        = ST_OK;
        r.entry_index   = out_idx(pos);
        r.name_high_out = e.key.hi;
        r.name_mid_out  = e.key.mid;
        r.name_low_out  = e.key.lo;
        r.phone_out     = e.phone;
        r.last          = lst;
        return r;
    endfunction

endpackage

FILE: hdl/ctss_cmp.sv
// Shared key comparator: lhs against rhs, unsigned over all 152 bits
module ctss_cmp (
    input  ctss_pkg::key_t     lhs,
    input  ctss_pkg::key_t     rhs,
    output ctss_pkg::cmp_res_t res
);
    import ctss_pkg::*;

    assign res.lt = (lhs < rhs);
    assign res.eq = (lhs == rhs);

endmodule

FILE: hdl/ctss_table.sv
// Entry storage: one write port, two read ports with registered data
module ctss_table (
    input  logic                        clk,
    input  logic                        ren,
    input  logic [ctss_pkg::IDX_W-1:0]  raddr_a,
    input  logic [ctss_pkg::IDX_W-1:0]  raddr_b,
    input  logic                        wen,
    input  logic [ctss_pkg::IDX_W-1:0]  waddr,
    input  ctss_pkg::entry_t            wdata,
    output ctss_pkg::entry_t            rdata_a,
    output ctss_pkg::entry_t            rdata_b
);
    import ctss_pkg::*;

    entry_t mem [ENTRIES];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports, data held until the next read
    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: hdl/contact_table_sort_search.sv
// Contact table: insert, list, exchange sort, sequential and binary search.
// Insert writes the table on acceptance; list reads and emits each entry in turn;
// searches read and compare each probed entry; sort reads and compares each pair,
// then writes both slots when the pair swaps. One item at a time: a new transfer is
// taken once the sequencer is idle, set by the single comparator and one write port.
// Reset clears the entry count and the output valid; table contents stay undefined.
module contact_table_sort_search (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  ctss_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output ctss_pkg::rsp_t  rsp
);
    import ctss_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_RD     = 6'b000010,
        S_CMP    = 6'b000100,
        S_SWAP_I = 6'b001000,
        S_SWAP_J = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;
    rsp_t               res_reg, res_next;
    logic [2:0]         op_reg, op_next;
    key_t               key_reg, key_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;     // one past the upper bound
    logic [CNT_W-1:0]   mid_reg, mid_next;

    logic               ren;
    logic               wen;
    logic [IDX_W-1:0]   raddr_a;
    logic [IDX_W-1:0]   waddr;
    entry_t             wdata;
    entry_t             rdata_a;
    entry_t             rdata_b;
    key_t               cmp_lhs;
    key_t               cmp_rhs;
    cmp_res_t           cmp;

    logic [CNT_W:0]     mid_sum;
    logic [CNT_W-1:0]   mid;
    logic [CNT_W-1:0]   i_inc;
    logic [CNT_W-1:0]   j_inc;
    logic [CNT_W-1:0]   i_inc2;
    logic [CNT_W-1:0]   mid_inc;
    logic [CNT_W-1:0]   lo_new;
    logic [CNT_W-1:0]   hi_new;
    logic               cmp_gt;
    logic               req_xfer;
    logic               emit_free;

    ctss_table u_table (
        .clk     (clk),
        .ren     (ren),
        .raddr_a (raddr_a),
        .raddr_b (j_reg[IDX_W-1:0]),
        .wen     (wen),
        .waddr   (waddr),
        .wdata   (wdata),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Sort compares slot i against slot j; searches compare the query key
    assign cmp_lhs = (op_reg == OP_SORT) ? rdata_a.key : key_reg;
    assign cmp_rhs = (op_reg == OP_SORT) ? rdata_b.key : rdata_a.key;

    ctss_cmp u_cmp (
        .lhs (cmp_lhs),
        .rhs (cmp_rhs),
        .res (cmp)
    );

    // Loop arithmetic
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W+1)'(1);
    assign mid      = mid_sum[CNT_W:1];
    assign i_inc    = i_reg + CNT_W'(1);
    assign j_inc    = j_reg + CNT_W'(1);
    assign i_inc2   = i_reg + CNT_W'(2);
    assign mid_inc  = mid_reg + CNT_W'(1);
    assign lo_new   = cmp.lt ? lo_reg : mid_inc;
    assign hi_new   = cmp.lt ? mid_reg : hi_reg;
    assign cmp_gt   = !cmp.lt && !cmp.eq;

    assign req_ready = (state_reg == S_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign emit_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        res_next       = res_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        ren            = 1'b0;
        wen            = 1'b0;
        raddr_a        = i_reg[IDX_W-1:0];
        waddr          = cnt_reg[IDX_W-1:0];
        wdata          = rdata_a;

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    op_next  = req.op;
                    key_next = {req.key_word_high, req.key_word_mid, req.key_word_low};
                    case (req.op)
                        OP_INSERT:
                        begin
                            state_next = S_EMIT;
                            if (cnt_reg == CNT_W'(ENTRIES))
                            begin
                                res_next = make_status(ST_FULL);
                            end
                            else
                            begin
                                wen       = 1'b1;
                                wdata.key = {req.key_word_high, req.key_word_mid,
                                             req.key_word_low};
                                wdata.phone = req.phone_in;
                                cnt_next  = cnt_reg + CNT_W'(1);
                                res_next  = make_entry(wdata, cnt_reg, 1'b1);
                            end
                        end
                        OP_LIST, OP_SSEARCH:
                        begin
                            i_next = '0;
                            if (cnt_reg == '0)
                            begin
                                res_next   = make_status(ST_EMPTY);
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        OP_SORT:
                        begin
                            i_next = '0;
                            j_next = CNT_W'(1);
                            if (cnt_reg <= CNT_W'(1))
                            begin
                                res_next   = make_status(ST_FEW);
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        OP_BSEARCH:
                        begin
                            lo_next = '0;
                            hi_next = cnt_reg;
                            if (cnt_reg == '0)
                            begin
                                res_next   = make_status(ST_EMPTY);
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                ren = 1'b1;
                if (op_reg == OP_BSEARCH)
                begin
                    raddr_a  = mid[IDX_W-1:0];
                    mid_next = mid;
                end
                state_next = S_CMP;
            end

            S_CMP:
            begin
                case (op_reg)
                    OP_LIST:
                    begin
                        res_next   = make_entry(rdata_a, i_reg, i_inc == cnt_reg);
                        state_next = S_EMIT;
                    end
                    OP_SORT:
                    begin
                        if (cmp_gt)
                        begin
                            state_next = S_SWAP_I;
                        end
                        else if (j_inc < cnt_reg)
                        begin
                            j_next     = j_inc;
                            state_next = S_RD;
                        end
                        else if (i_inc2 < cnt_reg)
                        begin
                            i_next     = i_inc;
                            j_next     = i_inc2;
                            state_next = S_RD;
                        end
                        else
                        begin
                            res_next   = make_status(ST_OK);
                            state_next = S_EMIT;
                        end
                    end
                    OP_SSEARCH:
                    begin
                        if (cmp.eq)
                        begin
                            res_next   = make_entry(rdata_a, i_reg, 1'b1);
                            state_next = S_EMIT;
                        end
                        else if (i_inc == cnt_reg)
                        begin
                            res_next   = make_status(ST_MISS);
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            i_next     = i_inc;
                            state_next = S_RD;
                        end
                    end
                    OP_BSEARCH:
                    begin
                        if (cmp.eq)
                        begin
                            res_next   = make_entry(rdata_a, mid_reg, 1'b1);
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            lo_next = lo_new;
                            hi_next = hi_new;
                            if (lo_new < hi_new)
                            begin
                                state_next = S_RD;
                            end
                            else
                            begin
                                res_next   = make_status(ST_MISS);
                                state_next = S_EMIT;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // Swap: slot i takes entry j, then slot j takes entry i
            S_SWAP_I:
            begin
                wen        = 1'b1;
                waddr      = i_reg[IDX_W-1:0];
                wdata      = rdata_b;
                state_next = S_SWAP_J;
            end

            S_SWAP_J:
            begin
                wen   = 1'b1;
                waddr = j_reg[IDX_W-1:0];
                wdata = rdata_a;
                if (j_inc < cnt_reg)
                begin
                    j_next     = j_inc;
                    state_next = S_RD;
                end
                else if (i_inc2 < cnt_reg)
                begin
                    i_next     = i_inc;
                    j_next     = i_inc2;
                    state_next = S_RD;
                end
                else
                begin
                    res_next   = make_status(ST_OK);
                    state_next = S_EMIT;
                end
            end

            // Hand the result to the output register once it is free
            S_EMIT:
            begin
                if (emit_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    if (op_reg == OP_LIST && !res_reg.last)
                    begin
                        i_next     = i_inc;
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        res_reg <= res_next;
        op_reg  <= op_next;
        key_reg <= key_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
    end

endmodule
